[rtl/q24_pkg.sv]
`timescale 1ns / 1ps

package q24_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_FROM_INT = 4'd8,
      OP_TO_INT   = 4'd9
   } op_type;

   localparam logic [31:0] MAX32 = 32'h7fff_ffff;
   localparam logic [31:0] MIN32 = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        less;
      logic        equal;
      logic        greater;
      logic        overflow;
      logic        div_zero;
   } rsp_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } sat_type;

   // Everything that rides alongside the divider.
   typedef struct packed {
      logic        valid;
      op_type      op;
      sat_type     simple;
      logic        less;
      logic        equal;
      logic        greater;
      logic        neg;
      logic        a_zero;
      logic        a_neg;
      logic        b_zero;
   } meta_type;

   // Signed result from a magnitude and a sign, clamped to 32 bits.
   function automatic sat_type sat_mag(input logic [63:0] mag, input logic neg);
      sat_type s;
      s.ovf = 1'b0;
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            s.value = MIN32;
            s.ovf   = 1'b1;
         end else begin
            s.value = 32'(~mag[31:0] + 32'd1);
         end
      end else begin
         if (mag > 64'h7fff_ffff) begin
            s.value = MAX32;
            s.ovf   = 1'b1;
         end else begin
            s.value = mag[31:0];
         end
      end
      return s;
   endfunction

   // Clamp a 33-bit signed sum to 32 bits.
   function automatic sat_type sat33(input logic [32:0] v);
      sat_type s;
      s.ovf = v[32] != v[31];
      if (s.ovf) begin
         s.value = v[32] ? MIN32 : MAX32;
      end else begin
         s.value = v[31:0];
      end
      return s;
   endfunction

endpackage

[rtl/q24_8_fixed_point_alu_unit.sv]
`timescale 1ns / 1ps
// From start to rsp_valid a request passes the input register, the divider
// stages, which resolve one quotient bit per stage, and the output register.
// Throughput: one operation per cycle; busy is never raised.
// Reset clears every valid bit in the pipeline; data registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.

module q24_8_fixed_point_alu_unit import q24_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int NW  = 32 + FRAC_BITS;
   localparam int LAT = NW + 2;

   logic signed [31:0] a;
   logic signed [31:0] b;
   logic [31:0]        ma;
   logic [31:0]        mb;
   logic [32:0]        sum;
   logic [31+FRAC_BITS:0] fi;
   logic [32:0]        bias;
   logic signed [32:0] ti;
   meta_type           meta_in;
   meta_type           meta_ff;
   logic [31:0]        ma_ff;
   logic [31:0]        mb_ff;

   meta_type           line_ff [NW];
   sat_type            mul_out;
   sat_type            mline_ff [NW-2];

   logic [NW-1:0]      quo;
   logic [31:0]        rem;
   logic [31:0]        den;
   logic [NW:0]        qr;
   sat_type            dsat;
   rsp_type            rsp_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   assign busy = 1'b0;
   assign a    = req_data.operand_a;
   assign b    = req_data.operand_b;

   // Front stage: magnitudes, compares and every op but multiply and divide.
   always_comb begin
      ma   = a[31] ? (~a + 32'd1) : a;
      mb   = b[31] ? (~b + 32'd1) : b;
      fi   = {{FRAC_BITS{a[31]}}, a} << FRAC_BITS;
      bias = a[31] ? ((33'd1 << FRAC_BITS) - 33'd1) : 33'd0;
      ti   = {a[31], a} + bias;
      sum  = '0;

      meta_in         = '0;
      meta_in.valid   = start;
      meta_in.op      = op_type'(req_data.op);
      meta_in.less    = a < b;
      meta_in.equal   = a == b;
      meta_in.greater = a > b;
      meta_in.neg     = a[31] != b[31];
      meta_in.a_zero  = a == 32'sd0;
      meta_in.a_neg   = a[31];
      meta_in.b_zero  = b == 32'sd0;
      meta_in.simple  = '0;

      unique case (meta_in.op)
         OP_ADD: begin
            sum            = {a[31], a} + {b[31], b};
            meta_in.simple = sat33(sum);
         end
         OP_SUB: begin
            sum            = {a[31], a} - {b[31], b};
            meta_in.simple = sat33(sum);
         end
         OP_INC: begin
            sum            = {a[31], a} + 33'd1;
            meta_in.simple = sat33(sum);
         end
         OP_DEC: begin
            sum            = {a[31], a} - 33'd1;
            meta_in.simple = sat33(sum);
         end
         OP_MIN: meta_in.simple.value = (a < b) ? a : b;
         OP_MAX: meta_in.simple.value = (a > b) ? a : b;
         OP_FROM_INT: begin
            if (fi[31+FRAC_BITS:31] != '0 && fi[31+FRAC_BITS:31] != '1) begin
               meta_in.simple.ovf   = 1'b1;
               meta_in.simple.value = fi[31+FRAC_BITS] ? MIN32 : MAX32;
            end else begin
               meta_in.simple.value = fi[31:0];
            end
         end
         OP_TO_INT: meta_in.simple.value = 32'(ti >>> FRAC_BITS);
         default: meta_in.simple = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.op      <= meta_in.op;
      meta_ff.simple  <= meta_in.simple;
      meta_ff.less    <= meta_in.less;
      meta_ff.equal   <= meta_in.equal;
      meta_ff.greater <= meta_in.greater;
      meta_ff.neg     <= meta_in.neg;
      meta_ff.a_zero  <= meta_in.a_zero;
      meta_ff.a_neg   <= meta_in.a_neg;
      meta_ff.b_zero  <= meta_in.b_zero;
      ma_ff           <= ma;
      mb_ff           <= mb;
   end

   q24_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .mag_a   (ma_ff),
      .mag_b   (mb_ff),
      .neg     (meta_ff.neg),
      .mul_out (mul_out)
   );

   q24_div #(
      .NW(NW)
   ) u_div (
      .clock   (clock),
      .num     ({ma_ff, {FRAC_BITS{1'b0}}}),
      .den     (mb_ff),
      .quo     (quo),
      .rem     (rem),
      .den_out (den)
   );

   // Carry side data in step with the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            line_ff[i].valid <= 1'b0;
         end
      end else begin
         line_ff[0].valid <= meta_ff.valid;
         for (int i = 1; i < NW; i++) begin
            line_ff[i].valid <= line_ff[i-1].valid;
         end
      end
      line_ff[0].op      <= meta_ff.op;
      line_ff[0].simple  <= meta_ff.simple;
      line_ff[0].less    <= meta_ff.less;
      line_ff[0].equal   <= meta_ff.equal;
      line_ff[0].greater <= meta_ff.greater;
      line_ff[0].neg     <= meta_ff.neg;
      line_ff[0].a_zero  <= meta_ff.a_zero;
      line_ff[0].a_neg   <= meta_ff.a_neg;
      line_ff[0].b_zero  <= meta_ff.b_zero;
      for (int i = 1; i < NW; i++) begin
         line_ff[i].op      <= line_ff[i-1].op;
         line_ff[i].simple  <= line_ff[i-1].simple;
         line_ff[i].less    <= line_ff[i-1].less;
         line_ff[i].equal   <= line_ff[i-1].equal;
         line_ff[i].greater <= line_ff[i-1].greater;
         line_ff[i].neg     <= line_ff[i-1].neg;
         line_ff[i].a_zero  <= line_ff[i-1].a_zero;
         line_ff[i].a_neg   <= line_ff[i-1].a_neg;
         line_ff[i].b_zero  <= line_ff[i-1].b_zero;
      end
      mline_ff[0] <= mul_out;
      for (int i = 1; i < NW - 2; i++) begin
         mline_ff[i] <= mline_ff[i-1];
      end
   end

   // Final stage: round the quotient and pick the result by opcode.
   always_comb begin
      qr   = {1'b0, quo} + {{NW{1'b0}}, ({rem, 1'b0} >= {1'b0, den})};
      dsat = sat_mag(64'(qr), line_ff[NW-1].neg);

      rsp_in          = '0;
      rsp_in.less     = line_ff[NW-1].less;
      rsp_in.equal    = line_ff[NW-1].equal;
      rsp_in.greater  = line_ff[NW-1].greater;
      rsp_in.result   = line_ff[NW-1].simple.value;
      rsp_in.overflow = line_ff[NW-1].simple.ovf;

      unique case (line_ff[NW-1].op)
         OP_MUL: begin
            rsp_in.result   = mline_ff[NW-3].value;
            rsp_in.overflow = mline_ff[NW-3].ovf;
         end
         OP_DIV: begin
            if (line_ff[NW-1].b_zero) begin
               rsp_in.div_zero = 1'b1;
               if (line_ff[NW-1].a_zero) begin
                  rsp_in.result   = '0;
                  rsp_in.overflow = 1'b0;
               end else begin
                  rsp_in.result   = line_ff[NW-1].a_neg ? MIN32 : MAX32;
                  rsp_in.overflow = 1'b1;
               end
            end else begin
               rsp_in.result   = dsat.value;
               rsp_in.overflow = dsat.ovf;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= line_ff[NW-1].valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without a matching start");

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.less, rsp_data.equal, rsp_data.greater}))
      else $error("compare flags not one-hot");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_zero && !rsp_data.overflow) |-> rsp_data.result == '0)
      else $error("0/0 must give zero");

endmodule

[rtl/q24_mul.sv]
`timescale 1ns / 1ps

module q24_mul import q24_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic [31:0] mag_a,
   input  logic [31:0] mag_b,
   input  logic        neg,
   output sat_type     mul_out
);

   logic [63:0] prod_ff;
   logic        neg_ff;
   logic [64:0] rnd;
   sat_type     res_in;
   sat_type     res_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mag_a * mag_b;
      neg_ff  <= neg;
      res_ff  <= res_in;
   end

   // Round half away from zero on the magnitude.
   always_comb begin
      rnd    = ({1'b0, prod_ff} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      res_in = sat_mag(rnd[63:0], neg_ff);
   end

   assign mul_out = res_ff;

endmodule

[rtl/q24_div.sv]
`timescale 1ns / 1ps

module q24_div #(
   parameter int NW = 40
) (
   input  logic            clock,
   input  logic [NW-1:0]   num,
   input  logic [31:0]     den,
   output logic [NW-1:0]   quo,
   output logic [31:0]     rem,
   output logic [31:0]     den_out
);

   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [31:0]   rem_ff [NW];
   logic [31:0]   den_ff [NW];

   // One quotient bit per stage, restoring.
   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [NW-1:0] num_prev;
      logic [NW-1:0] quo_prev;
      logic [31:0]   rem_prev;
      logic [31:0]   den_prev;
      logic [32:0]   trial;
      logic [32:0]   diff;

      if (i == 0) begin : g_first
         assign num_prev = num;
         assign quo_prev = '0;
         assign rem_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign num_prev = num_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      assign trial = {rem_prev, num_prev[NW-1]};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         num_ff[i] <= num_prev << 1;
         den_ff[i] <= den_prev;
         if (!diff[32]) begin
            rem_ff[i] <= diff[31:0];
            quo_ff[i] <= {quo_prev[NW-2:0], 1'b1};
         end else begin
            rem_ff[i] <= trial[31:0];
            quo_ff[i] <= {quo_prev[NW-2:0], 1'b0};
         end
      end
   end

   assign quo     = quo_ff[NW-1];
   assign rem     = rem_ff[NW-1];
   assign den_out = den_ff[NW-1];

endmodule

[tb/q24_8_fixed_point_alu_unit_tb.sv]
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_unit_tb;
   import q24_pkg::*;

   localparam int FRAC = 8;
   localparam int LATENCY = FRAC + 34;
   localparam longint LIMIT = 400000;
   localparam int N_RANDOM = 1700;
   localparam logic [31:0] ZERO32 = 32'd0;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_rsp[$];
   int      error_count;
   longint  cycle_count;
   int      send_idle_pct;

   typedef struct {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      bit          known;
      rsp_type     rsp;
   } row_type;

   row_type rows[$];

   q24_8_fixed_point_alu_unit #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] clamp_q(input longint v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return MAX32;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return MIN32;
      end
      return v[31:0];
   endfunction

   function automatic rsp_type alu_predict(input logic [3:0] op, input logic [31:0] ra,
                                           input logic [31:0] rb);
      rsp_type     r;
      longint      a, b, q;
      longint unsigned ma, mb, p, num;
      logic        ovf;
      bit          neg;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      ovf = 1'b0;
      r = '0;
      case (op)
         OP_ADD: r.result = clamp_q(a + b, ovf);
         OP_SUB: r.result = clamp_q(a - b, ovf);
         OP_MUL: begin
            p = ma * mb;
            q = longint'((p + (64'd1 << (FRAC - 1))) >> FRAC);
            r.result = clamp_q(neg ? -q : q, ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.div_zero = 1'b1;
               if (a > 0) begin
                  r.result = MAX32;
                  ovf = 1'b1;
               end else if (a < 0) begin
                  r.result = MIN32;
                  ovf = 1'b1;
               end else begin
                  r.result = ZERO32;
               end
            end else begin
               num = ma << FRAC;
               q = longint'((2 * num + mb) / (2 * mb));
               r.result = clamp_q(neg ? -q : q, ovf);
            end
         end
         OP_MIN: r.result = a < b ? ra : rb;
         OP_MAX: r.result = a > b ? ra : rb;
         OP_INC: r.result = clamp_q(a + 1, ovf);
         OP_DEC: r.result = clamp_q(a - 1, ovf);
         OP_FROM_INT: r.result = clamp_q(a * (64'sd1 <<< FRAC), ovf);
         OP_TO_INT: r.result = 32'(a / (64'sd1 <<< FRAC));
         default: r.result = ZERO32;
      endcase
      r.overflow = ovf;
      r.less = a < b;
      r.equal = a == b;
      r.greater = a > b;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
   endtask

   task automatic add_row(input op_type op, input logic [31:0] a, input logic [31:0] b,
                          input bit known, input logic [31:0] res, input logic ovf,
                          input logic dz);
      row_type w;
      w.op = op;
      w.a = a;
      w.b = b;
      w.known = known;
      w.rsp = alu_predict(op, a, b);
      if (known) begin
         w.rsp.result = res;
         w.rsp.overflow = ovf;
         w.rsp.div_zero = dz;
      end
      rows.push_back(w);
   endtask

   // Hold start and data until the transfer is taken at a rising edge.
   task automatic send_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                            input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{op: op, operand_a: a, operand_b: b};
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(want);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return MAX32;
         1: return MIN32;
         2: return ZERO32;
         3: return 32'($urandom_range(2048)) - 32'd1024;
         4: return {$urandom_range(1) ? 12'hfff : 12'h000, 20'($urandom)};
         5: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > LIMIT) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.result, ZERO32);
            end else begin
               rsp_type w;
               w = pending_rsp.pop_front();
               if (rsp_data.result !== w.result)
                  report_mismatch("result", rsp_data.result, w.result);
               if (rsp_data.less !== w.less)
                  report_mismatch("less", 32'(rsp_data.less), 32'(w.less));
               if (rsp_data.equal !== w.equal)
                  report_mismatch("equal", 32'(rsp_data.equal), 32'(w.equal));
               if (rsp_data.greater !== w.greater)
                  report_mismatch("greater", 32'(rsp_data.greater), 32'(w.greater));
               if (rsp_data.overflow !== w.overflow)
                  report_mismatch("overflow", 32'(rsp_data.overflow), 32'(w.overflow));
               if (rsp_data.div_zero !== w.div_zero)
                  report_mismatch("div_zero", 32'(rsp_data.div_zero), 32'(w.div_zero));
            end
         end
      end
   end

   initial begin
      logic [3:0]  op;
      logic [31:0] a, b;
      int          drain;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(OP_ADD, MAX32, 32'd1, 1, MAX32, 1, 0);
      add_row(OP_ADD, MIN32, 32'hffff_ffff, 1, MIN32, 1, 0);
      add_row(OP_SUB, MIN32, 32'd1, 1, MIN32, 1, 0);
      add_row(OP_SUB, MAX32, MIN32, 1, MAX32, 1, 0);
      add_row(OP_MUL, 32'h0000_0180, 32'h0000_0001, 0, 0, 0, 0);  // tie rounds away
      add_row(OP_MUL, 32'hffff_fe80, 32'h0000_0001, 0, 0, 0, 0);
      add_row(OP_MUL, MAX32, MAX32, 1, MAX32, 1, 0);
      add_row(OP_MUL, MIN32, MAX32, 1, MIN32, 1, 0);
      add_row(OP_MUL, MIN32, MIN32, 1, MAX32, 1, 0);
      add_row(OP_DIV, 32'd5, ZERO32, 1, MAX32, 1, 1);
      add_row(OP_DIV, 32'hffff_fffb, ZERO32, 1, MIN32, 1, 1);
      add_row(OP_DIV, ZERO32, ZERO32, 1, ZERO32, 0, 1);
      add_row(OP_DIV, MIN32, 32'd1, 1, MIN32, 1, 0);
      add_row(OP_DIV, 32'd1, 32'd3, 0, 0, 0, 0);
      add_row(OP_DIV, MIN32, 32'hffff_ffff, 0, 0, 0, 0);
      add_row(OP_MIN, MIN32, MAX32, 1, MIN32, 0, 0);
      add_row(OP_MAX, MIN32, MAX32, 1, MAX32, 0, 0);
      add_row(OP_INC, MAX32, ZERO32, 1, MAX32, 1, 0);
      add_row(OP_DEC, MIN32, ZERO32, 1, MIN32, 1, 0);
      add_row(OP_FROM_INT, 32'h0080_0000, ZERO32, 1, MAX32, 1, 0);
      add_row(OP_FROM_INT, 32'hff7f_ffff, ZERO32, 1, MIN32, 1, 0);
      add_row(OP_TO_INT, 32'hffff_ff01, ZERO32, 1, ZERO32, 0, 0);
      add_row(OP_TO_INT, MIN32, MAX32, 1, 32'hff80_0000, 0, 0);
      add_row(op_type'(4'd15), MAX32, MAX32, 1, ZERO32, 0, 0);
      add_row(op_type'(4'd10), ZERO32, MIN32, 1, ZERO32, 0, 0);
      foreach (rows[i]) send_item(rows[i].op, rows[i].a, rows[i].b, rows[i].rsp);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n < N_RANDOM / 3) send_idle_pct = 8;
         else if (n < 2 * N_RANDOM / 3) send_idle_pct = 84;
         else send_idle_pct = 0;
         op = $urandom_range(19) == 0 ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
         a = pick_operand();
         b = $urandom_range(15) == 0 ? a : pick_operand();
         send_item(op, a, b, alu_predict(op, a, b));
      end
      start <= 1'b0;

      drain = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      while (drain < LATENCY + 8) begin
         @(posedge clock);
         drain++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
